FILE: hdl/sct_pkg.sv
// Shared types, constants and step tables for the silhouette contour tracer.
package sct_pkg;

  // Image size limits and derived widths.
  localparam int MAX_WIDTH_PIXELS  = 64;
  localparam int MAX_HEIGHT_PIXELS = 64;
  localparam int MASK_DEPTH        = MAX_WIDTH_PIXELS * MAX_HEIGHT_PIXELS;
  localparam int XW                = $clog2(MAX_WIDTH_PIXELS);
  localparam int YW                = $clog2(MAX_HEIGHT_PIXELS);
  localparam int EWW               = $clog2(MAX_WIDTH_PIXELS + 1);
  localparam int EHW               = $clog2(MAX_HEIGHT_PIXELS + 1);
  localparam int CW                = ((XW > YW) ? XW : YW) + 2;
  localparam int ADDR_W            = $clog2(MASK_DEPTH);
  localparam int TOT_W             = $clog2(MASK_DEPTH + 1);
  localparam int PE_W              = TOT_W + 2;

  // Fixed field widths of the ports.
  localparam int ALPHA_W  = 8;
  localparam int SIZE_W   = 7;
  localparam int OUT_W    = 6;
  localparam int CFG_IW   = 2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IW-1:0] CFG_ALPHA_THRESHOLD = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT    = 2'd2;
  localparam logic [ALPHA_W-1:0] THRESHOLD_RESET    = 8'd48;
  localparam logic [SIZE_W-1:0]  WIDTH_RESET        = 7'd64;
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET       = 7'd64;

  // Input item kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRACE,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_CTR_RD,
    ST_CTR_EV,
    ST_NB_RD,
    ST_NB_EV,
    ST_NEXT,
    ST_HIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_we;
    logic res_done;
    logic res_empty;
    logic scan_init;
    logic search_begin;
    logic cand_ld;
    logic rd_nb;
    logic k_clr;
    logic k_inc;
    logic scan_adv;
    logic i_inc;
    logic scan_hit;
    logic search_hit;
    logic search_miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic   full;
    phase_t phase;
    logic   mode_scan;
    logic   cand_in;
    logic   nb_in;
    logic   rd_bit;
    logic   k_last;
    logic   i_last;
    logic   scan_last;
    logic   out_free;
  } status_t;

  // Moore neighbor steps: E, SE, S, SW, W, NW, N, NE (y grows downward).
  function automatic logic signed [CW-1:0] step_dx(input logic [2:0] d);
    logic signed [CW-1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = CW'(1);
      3'd3, 3'd4, 3'd5: v = -CW'(1);
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] step_dy(input logic [2:0] d);
    logic signed [CW-1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = CW'(1);
      3'd5, 3'd6, 3'd7: v = -CW'(1);
      default:          v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/sct_ctrl.sv
// Controller state machine that sequences loads, the start scan and neighbor searches.
module sct_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_stall,
  input  sct_pkg::status_t status,
  output sct_pkg::cmd_t    cmd
);
  import sct_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_REQUEST && status.full) begin
          if (status.phase == PH_DONE) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CAND;
          end
        end
      end
      ST_CAND:   state_nxt = ST_CTR_RD;
      ST_CTR_RD: state_nxt = status.cand_in ? ST_CTR_EV : ST_NEXT;
      ST_CTR_EV: state_nxt = status.rd_bit ? ST_NB_RD : ST_NEXT;
      ST_NB_RD:  state_nxt = status.nb_in ? ST_NB_EV : ST_HIT;
      ST_NB_EV: begin
        if (!status.rd_bit) begin
          state_nxt = ST_HIT;
        end else if (status.k_last) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_NB_RD;
        end
      end
      ST_NEXT: begin
        if (status.mode_scan) begin
          state_nxt = status.scan_last ? ST_EMIT : ST_CAND;
        end else begin
          state_nxt = status.i_last ? ST_EMIT : ST_CAND;
        end
      end
      ST_HIT:  state_nxt = status.mode_scan ? ST_CAND : ST_EMIT;
      ST_EMIT: state_nxt = status.out_free ? ST_IDLE : ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_we = 1'b1;
          end else if (status.full) begin
            case (status.phase)
              PH_DONE:  cmd.res_done     = 1'b1;
              PH_TRACE: cmd.search_begin = 1'b1;
              default:  cmd.scan_init    = 1'b1;
            endcase
          end
        end
      end
      ST_CAND:   cmd.cand_ld = 1'b1;
      ST_CTR_EV: cmd.k_clr   = status.rd_bit;
      ST_NB_RD:  cmd.rd_nb   = 1'b1;
      ST_NB_EV:  cmd.k_inc   = status.rd_bit && !status.k_last;
      ST_NEXT: begin
        if (status.mode_scan) begin
          cmd.res_empty = status.scan_last;
          cmd.scan_adv  = !status.scan_last;
        end else begin
          cmd.search_miss = status.i_last;
          cmd.i_inc       = !status.i_last;
        end
      end
      ST_HIT: begin
        cmd.scan_hit   = status.mode_scan;
        cmd.search_hit = !status.mode_scan;
      end
      ST_EMIT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/sct_datapath.sv
// Datapath: configuration, opaque mask memory, trace registers and the output register.
module sct_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sct_pkg::cmd_t                   cmd,
  output sct_pkg::status_t                status,
  input  logic [sct_pkg::ALPHA_W-1:0]     in_alpha,
  input  logic                            cfg_we,
  input  logic [sct_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [sct_pkg::ALPHA_W-1:0]     cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sct_pkg::OUT_W-1:0]       out_point_x,
  output logic [sct_pkg::OUT_W-1:0]       out_point_y,
  output logic                            out_point_valid,
  output logic                            out_last_point
);
  import sct_pkg::*;

  // Configuration.
  logic [ALPHA_W-1:0] thr_r;
  logic [SIZE_W-1:0]  width_r, height_r;
  logic [EWW-1:0]     eff_w;
  logic [EHW-1:0]     eff_h;
  logic [TOT_W-1:0]   total;
  logic [PE_W-1:0]    limit;

  // Trace state.
  logic [TOT_W-1:0]   lp_r, lp_eff;
  phase_t             phase_r;
  logic               mode_scan_r;
  logic [XW-1:0]      scan_x_r, cur_x_r, start_x_r, res_x_r;
  logic [YW-1:0]      scan_y_r, cur_y_r, start_y_r, res_y_r;
  logic [2:0]         dir_r, i_r, k_r, nd;
  logic [PE_W-1:0]    pe_r;
  logic               res_valid_r, res_last_r;
  logic signed [CW-1:0] cand_x_r, cand_y_r, cand_x_nxt, cand_y_nxt;
  logic signed [CW-1:0] nb_x, nb_y, rd_x, rd_y;
  logic               at_start, hit_last;

  // Mask memory.
  logic               mask_mem [MASK_DEPTH];
  logic               rd_bit_r;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [YW+EWW-1:0]  row_base;

  // Output register.
  logic               out_valid_r;
  logic [XW-1:0]      out_x_r;
  logic [YW-1:0]      out_y_r;
  logic               out_pv_r, out_last_r;

  always_comb begin
    if (width_r == '0) begin
      eff_w = EWW'(1);
    end else if (int'(width_r) > MAX_WIDTH_PIXELS) begin
      eff_w = EWW'(MAX_WIDTH_PIXELS);
    end else begin
      eff_w = EWW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EHW'(1);
    end else if (int'(height_r) > MAX_HEIGHT_PIXELS) begin
      eff_h = EHW'(MAX_HEIGHT_PIXELS);
    end else begin
      eff_h = EHW'(height_r);
    end
  end

  assign total  = TOT_W'(eff_w) * TOT_W'(eff_h);
  assign limit  = {total, 2'b00};
  assign lp_eff = (lp_r >= total) ? '0 : lp_r;
  assign wr_addr = lp_eff[ADDR_W-1:0];

  function automatic logic in_image(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic [EWW-1:0] w,
                                    input logic [EHW-1:0] h);
    return !x[CW-1] && !y[CW-1] && (x < signed'(CW'(w))) && (y < signed'(CW'(h)));
  endfunction

  // Candidate for the next edge test: raster scan position or a neighbor of the current point.
  assign nd = dir_r + 3'd5 + i_r;
  always_comb begin
    if (mode_scan_r) begin
      cand_x_nxt = signed'(CW'(scan_x_r));
      cand_y_nxt = signed'(CW'(scan_y_r));
    end else begin
      cand_x_nxt = signed'(CW'(cur_x_r)) + step_dx(nd);
      cand_y_nxt = signed'(CW'(cur_y_r)) + step_dy(nd);
    end
  end

  assign nb_x = cand_x_r + step_dx(k_r);
  assign nb_y = cand_y_r + step_dy(k_r);
  assign rd_x = cmd.rd_nb ? nb_x : cand_x_r;
  assign rd_y = cmd.rd_nb ? nb_y : cand_y_r;
  assign row_base = rd_y[YW-1:0] * eff_w;
  assign rd_addr  = ADDR_W'(row_base + (YW+EWW)'(rd_x[XW-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mask_mem[wr_addr] <= (in_alpha > thr_r);
    end
    rd_bit_r <= mask_mem[rd_addr];
  end

  assign at_start = (cand_x_r == signed'(CW'(start_x_r))) &&
                    (cand_y_r == signed'(CW'(start_y_r)));
  assign hit_last = ((pe_r > PE_W'(2)) && at_start) || (pe_r >= limit);

  // Configuration and trace control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RESET;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      lp_r        <= '0;
      phase_r     <= PH_IDLE;
      mode_scan_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      dir_r       <= '0;
      pe_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_THRESHOLD: thr_r    <= cfg_data;
          CFG_IMAGE_WIDTH:     width_r  <= cfg_data[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT:    height_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_we) begin
        lp_r    <= lp_eff + TOT_W'(1);
        phase_r <= PH_IDLE;
      end
      if (cmd.res_empty) begin
        phase_r <= PH_DONE;
      end
      if (cmd.scan_init) begin
        mode_scan_r <= 1'b1;
      end
      if (cmd.search_begin) begin
        mode_scan_r <= 1'b0;
        pe_r        <= pe_r + PE_W'(1);
      end
      if (cmd.scan_hit) begin
        mode_scan_r <= 1'b0;
        phase_r     <= PH_TRACE;
        cur_x_r     <= cand_x_r[XW-1:0];
        cur_y_r     <= cand_y_r[YW-1:0];
        start_x_r   <= cand_x_r[XW-1:0];
        start_y_r   <= cand_y_r[YW-1:0];
        dir_r       <= '0;
        pe_r        <= PE_W'(1);
      end
      if (cmd.search_hit) begin
        cur_x_r <= cand_x_r[XW-1:0];
        cur_y_r <= cand_y_r[YW-1:0];
        dir_r   <= nd;
        if (hit_last) begin
          phase_r <= PH_DONE;
        end
      end
      if (cmd.search_miss) begin
        phase_r <= PH_DONE;
      end
    end
  end

  // Scan position, loop counters, candidate and pending result.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_x_r <= '0;
      scan_y_r <= '0;
    end else if (cmd.scan_adv) begin
      if (EWW'(scan_x_r) == eff_w - EWW'(1)) begin
        scan_x_r <= '0;
        scan_y_r <= scan_y_r + YW'(1);
      end else begin
        scan_x_r <= scan_x_r + XW'(1);
      end
    end
    if (cmd.search_begin || cmd.scan_hit) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + 3'd1;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 3'd1;
    end
    if (cmd.cand_ld) begin
      cand_x_r <= cand_x_nxt;
      cand_y_r <= cand_y_nxt;
    end
    if (cmd.res_done || cmd.res_empty) begin
      res_x_r     <= '0;
      res_y_r     <= '0;
      res_valid_r <= 1'b0;
      res_last_r  <= cmd.res_empty;
    end else if (cmd.search_begin) begin
      res_x_r     <= cur_x_r;
      res_y_r     <= cur_y_r;
      res_valid_r <= 1'b1;
      res_last_r  <= 1'b0;
    end else if (cmd.scan_hit) begin
      res_x_r     <= cand_x_r[XW-1:0];
      res_y_r     <= cand_y_r[YW-1:0];
      res_valid_r <= 1'b1;
      res_last_r  <= 1'b0;
    end else if (cmd.search_hit) begin
      res_last_r <= hit_last;
    end else if (cmd.search_miss) begin
      res_last_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_pv_r   <= res_valid_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = OUT_W'(out_x_r);
  assign out_point_y     = OUT_W'(out_y_r);
  assign out_point_valid = out_pv_r;
  assign out_last_point  = out_last_r;

  always_comb begin
    status           = '0;
    status.full      = (lp_r >= total);
    status.phase     = phase_r;
    status.mode_scan = mode_scan_r;
    status.cand_in   = in_image(cand_x_r, cand_y_r, eff_w, eff_h);
    status.nb_in     = in_image(nb_x, nb_y, eff_w, eff_h);
    status.rd_bit    = rd_bit_r;
    status.k_last    = (k_r == 3'd7);
    status.i_last    = (i_r == 3'd7);
    status.scan_last = (EWW'(scan_x_r) == eff_w - EWW'(1)) &&
                       (EHW'(scan_y_r) == eff_h - EHW'(1));
    status.out_free  = !out_valid_r || !out_stall;
  end

endmodule

FILE: hdl/silhouette_contour_tracer.sv
// Top level of the silhouette contour tracer: controller, datapath and configuration port.
// Each load beat leaves the controller idle, so the input is ready again on the next cycle.
// A request reads the mask one bit at a time: up to 8 candidates of 9 reads each, the
// center and its eight neighbors; a request after the walk is done goes straight to output.
// The first request also scans the pixels in raster order to find the start of the walk.
// A result is held while out_stall is high; the next beat is taken the cycle after it loads.
// Reset (rst_n low, synchronous) restores 48/64/64 and forgets the load, not the mask.
module silhouette_contour_tracer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [sct_pkg::ALPHA_W-1:0] in_alpha,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sct_pkg::OUT_W-1:0]   out_point_x,
  output logic [sct_pkg::OUT_W-1:0]   out_point_y,
  output logic                        out_point_valid,
  output logic                        out_last_point,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sct_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sct_pkg::ALPHA_W-1:0] cfg_data
);
  import sct_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes are never held off, so the port is always ready.
  assign cfg_ready = 1'b1;

  // The controller walks the edge test pixel by pixel: the candidate center first,
  // then its eight neighbors until one is transparent or outside the image.
  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the opaque mask, the trace position and the output register,
  // so a finished result waits there while the next beat is accepted.
  sct_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_alpha        (in_alpha),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_valid (out_point_valid),
    .out_last_point  (out_last_point)
  );

endmodule

FILE: hdl/sct_checker.sv
// Port-level checker for the silhouette contour tracer and its bind statement.
module sct_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sct_pkg::OUT_W-1:0]   out_point_x,
  input logic [sct_pkg::OUT_W-1:0]   out_point_y,
  input logic                        out_point_valid,
  input logic                        out_last_point
);
  import sct_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) &&
      $stable(out_point_y) && $stable(out_point_valid) && $stable(out_last_point))
    else $error("result beat changed while stalled");

  // After a load beat the input is not stalled in the next cycle.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_LOAD |=> !in_stall)
    else $error("input stalled after a load beat");

  // A result that carries no point carries zero coordinates.
  a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_point_x == '0 && out_point_y == '0)
    else $error("coordinates set without a point");

  // A new result only follows a period of work on a request.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

endmodule

bind silhouette_contour_tracer sct_checker u_sct_checker (.*);

FILE: sim/silhouette_contour_tracer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the silhouette contour tracer: image loads, contour walks, register writes.
module silhouette_contour_tracer_tb;
  import sct_pkg::*;

  // One input beat: a pixel load or a contour point request.
  typedef struct packed {
    logic               kind;
    logic [ALPHA_W-1:0] alpha;
  } tracer_beat_t;

  // One result beat, laid out in port order.
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             valid;
    logic             last;
  } contour_point_t;

  // Picture styles used to fill an image.
  typedef enum int {
    ART_EMPTY,
    ART_SOLID,
    ART_NOISE,
    ART_BLOBS,
    ART_RAW
  } artwork_t;

  localparam int TARGET_BEATS = 1250;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_LOAD;
  logic [ALPHA_W-1:0] in_alpha = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   out_point_x;
  logic [OUT_W-1:0]   out_point_y;
  logic               out_point_valid;
  logic               out_last_point;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IW-1:0]  cfg_index = CFG_ALPHA_THRESHOLD;
  logic [ALPHA_W-1:0] cfg_data = '0;

  silhouette_contour_tracer uut (.*);

  always #5 clk = ~clk;

  // Beats waiting to be driven, and the contour points the block still owes us.
  tracer_beat_t   trace_cmds[$];
  contour_point_t contour_expect_q[$];
  tracer_beat_t   next_beat;
  contour_point_t seen_point;
  contour_point_t want_point;

  int send_wait = 0;
  int recv_wait = 0;
  int send_pace = 1;
  int recv_pace = 1;
  int fault_count = 0;
  int beats_planned = 0;

  // Shadow of the tracer: register copies, the opaque bit map and the walk state.
  logic [ALPHA_W-1:0] thr_reg = THRESHOLD_RESET;
  logic [SIZE_W-1:0]  width_reg = WIDTH_RESET;
  logic [SIZE_W-1:0]  height_reg = HEIGHT_RESET;
  bit                 opaque_bits[MASK_DEPTH];
  int                 load_pos = 0;
  int                 cur_x = 0;
  int                 cur_y = 0;
  int                 org_x = 0;
  int                 org_y = 0;
  int                 heading = 0;
  int                 emitted = 0;
  phase_t             tphase = PH_IDLE;

  // A size register of zero means one pixel; anything past the array size is clamped.
  function automatic int span(logic [SIZE_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int cols();
    return span(width_reg, MAX_WIDTH_PIXELS);
  endfunction

  function automatic int rows();
    return span(height_reg, MAX_HEIGHT_PIXELS);
  endfunction

  // Everything outside the image counts as transparent.
  function automatic bit opaque_at(int x, int y);
    if (x < 0 || y < 0 || x >= cols() || y >= rows()) return 1'b0;
    return opaque_bits[y * cols() + x];
  endfunction

  // Directions run E, SE, S, SW, W, NW, N, NE with y growing downward.
  function automatic int move_dx(int d);
    case (d)
      0, 1, 7: return 1;
      3, 4, 5: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int move_dy(int d);
    case (d)
      1, 2, 3: return 1;
      5, 6, 7: return -1;
      default: return 0;
    endcase
  endfunction

  // An edge pixel is opaque with at least one transparent neighbor.
  function automatic bit edge_at(int x, int y);
    bit hit;
    hit = 1'b0;
    if (!opaque_at(x, y)) return 1'b0;
    for (int d = 0; d < 8; d++)
      if (!opaque_at(x + move_dx(d), y + move_dy(d))) hit = 1'b1;
    return hit;
  endfunction

  // Applies one accepted beat to the shadow and queues the point it should produce.
  function automatic void predict_contour_step(logic kind, logic [ALPHA_W-1:0] alpha);
    int total;
    int sd;
    int nd;
    int nx;
    int ny;
    bit found;
    bit finish;
    contour_point_t pt;
    total = cols() * rows();
    found = 1'b0;
    if (kind == KIND_LOAD) begin
      // A load into a full image starts the next image at the top left.
      if (load_pos >= total) load_pos = 0;
      opaque_bits[load_pos] = (alpha > thr_reg);
      load_pos++;
      tphase = PH_IDLE;
      return;
    end
    // Requests are dropped silently until the whole image is in.
    if (load_pos < total) return;
    if (tphase == PH_DONE) begin
      contour_expect_q.push_back('{x: '0, y: '0, valid: 1'b0, last: 1'b0});
      return;
    end
    if (tphase == PH_IDLE) begin
      // The walk starts at the first edge pixel in raster order.
      for (int y = 0; y < rows() && !found; y++)
        for (int x = 0; x < cols() && !found; x++)
          if (edge_at(x, y)) begin
            org_x = x;
            org_y = y;
            found = 1'b1;
          end
      if (!found) begin
        tphase = PH_DONE;
        contour_expect_q.push_back('{x: '0, y: '0, valid: 1'b0, last: 1'b1});
        return;
      end
      cur_x = org_x;
      cur_y = org_y;
      heading = 0;
      emitted = 0;
      tphase = PH_TRACE;
      found = 1'b0;
    end
    pt = '{x: cur_x[OUT_W-1:0], y: cur_y[OUT_W-1:0], valid: 1'b1, last: 1'b0};
    emitted++;
    // Search clockwise, starting one step past the way we came in.
    sd = (heading + 5) % 8;
    for (int i = 0; i < 8 && !found; i++) begin
      nd = (sd + i) % 8;
      nx = cur_x + move_dx(nd);
      ny = cur_y + move_dy(nd);
      if (edge_at(nx, ny)) begin
        cur_x = nx;
        cur_y = ny;
        heading = nd;
        found = 1'b1;
      end
    end
    finish = !found || (emitted > 2 && cur_x == org_x && cur_y == org_y) ||
             (emitted >= total * 4);
    if (finish) begin
      tphase = PH_DONE;
      pt.last = 1'b1;
    end
    contour_expect_q.push_back(pt);
  endfunction

  // Each side waits a random number of cycles per beat, or none at all in a busy stretch.
  function automatic int draw_wait(int pace);
    if (pace == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Input driver: every accepted beat goes through the shadow before the next is offered.
  // A stalled beat is held untouched; the gap after a beat only runs once it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_contour_step(in_kind, in_alpha);
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (trace_cmds.size() != 0) begin
          next_beat = trace_cmds.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_beat.kind;
          in_alpha <= next_beat.alpha;
          send_wait = draw_wait(send_pace);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken beat with the oldest expected point, then
  // holds stall for a fresh random count of cycles in which a result is on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_point = {out_point_x, out_point_y, out_point_valid, out_last_point};
        if (contour_expect_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected contour beat: x=%0d y=%0d valid=%0b last=%0b",
                     seen_point.x, seen_point.y, seen_point.valid, seen_point.last);
        end else begin
          want_point = contour_expect_q.pop_front();
          if (seen_point !== want_point) begin
            fault_count++;
            if (fault_count <= 10)
              $display("contour beat mismatch: expected x=%0d y=%0d valid=%0b last=%0b, got x=%0d y=%0d valid=%0b last=%0b",
                       want_point.x, want_point.y, want_point.valid, want_point.last,
                       seen_point.x, seen_point.y, seen_point.valid, seen_point.last);
          end
        end
        recv_wait = draw_wait(recv_pace);
      end else if (out_valid && recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0);
    end
  end

  function automatic void queue_beat(logic kind, logic [ALPHA_W-1:0] alpha);
    trace_cmds.push_back('{kind: kind, alpha: alpha});
  endfunction

  // Request beats carry random alpha, which the block must ignore.
  function automatic void ask_points(int n);
    repeat (n) queue_beat(KIND_REQUEST, ALPHA_W'($urandom_range(0, 255)));
    beats_planned += n;
  endfunction

  // An alpha that lands on the wanted side of the threshold, often right at it.
  function automatic logic [ALPHA_W-1:0] pick_alpha(bit solid);
    if (solid && thr_reg != 8'hFF) begin
      if ($urandom_range(0, 7) == 0) return thr_reg + 8'd1;
      return ALPHA_W'($urandom_range(thr_reg + 1, 255));
    end
    if (solid) return 8'hFF;
    if ($urandom_range(0, 7) == 0) return thr_reg;
    return ALPHA_W'($urandom_range(0, thr_reg));
  endfunction

  function automatic void paint_image(int w, int h, artwork_t art,
                                      ref logic [ALPHA_W-1:0] px[$]);
    int bx0;
    int bx1;
    int by0;
    int by1;
    int dens;
    int x;
    int y;
    bit solid;
    px.delete();
    bx0 = $urandom_range(0, w - 1);
    bx1 = $urandom_range(bx0, w - 1);
    by0 = $urandom_range(0, h - 1);
    by1 = $urandom_range(by0, h - 1);
    dens = $urandom_range(20, 90);
    for (int p = 0; p < w * h; p++) begin
      x = p % w;
      y = p / w;
      case (art)
        ART_EMPTY: solid = 1'b0;
        ART_SOLID: solid = 1'b1;
        ART_NOISE: solid = ($urandom_range(0, 99) < dens);
        ART_BLOBS: solid = (x >= bx0 && x <= bx1 && y >= by0 && y <= by1) ||
                           ($urandom_range(0, 40) == 0);
        default:   solid = 1'b0;
      endcase
      if (art == ART_RAW) px.push_back(ALPHA_W'($urandom_range(0, 255)));
      else px.push_back(pick_alpha(solid));
    end
  endfunction

  // Loads pixels from index first on; now and then a request slips in mid-load,
  // where it must produce nothing.
  function automatic void queue_pixels(ref logic [ALPHA_W-1:0] px[$], input int first);
    for (int p = first; p < px.size(); p++) begin
      queue_beat(KIND_LOAD, px[p]);
      beats_planned++;
      if (p + 1 < px.size() && $urandom_range(0, 30) == 0)
        queue_beat(KIND_REQUEST, ALPHA_W'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (trace_cmds.size() != 0 || in_valid || contour_expect_q.size() != 0);
  endtask

  // Loads leave no result behind, so give the block time to finish the last one.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called on a clock edge; leaves a quiet gap after each write so writes never collide.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [ALPHA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA_THRESHOLD: thr_reg = data;
      CFG_IMAGE_WIDTH:     width_reg = data[SIZE_W-1:0];
      CFG_IMAGE_HEIGHT:    height_reg = data[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One full image: settings, load, then contour requests until the walk is over.
  task automatic play_image(logic [ALPHA_W-1:0] thr, logic [ALPHA_W-1:0] wdat,
                            logic [ALPHA_W-1:0] hdat, artwork_t art);
    logic [ALPHA_W-1:0] px[$];
    int w;
    int h;
    int total;
    int asked;
    int chunk;
    bit aborted;
    wait_idle();
    send_pace = int'($urandom_range(0, 3) != 0);
    recv_pace = int'($urandom_range(0, 3) != 0);
    w = span(wdat[SIZE_W-1:0], MAX_WIDTH_PIXELS);
    h = span(hdat[SIZE_W-1:0], MAX_HEIGHT_PIXELS);
    total = w * h;
    write_reg(CFG_ALPHA_THRESHOLD, thr);
    // Rewind the load position without a reset: in a one pixel image the next load
    // lands on the top left pixel, which sits at the same place in every layout.
    // The rest of the new image then follows in its own layout, so nothing stale is read.
    write_reg(CFG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 1))});
    write_reg(CFG_IMAGE_HEIGHT, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 1))});
    paint_image(w, h, art, px);
    queue_beat(KIND_LOAD, px[0]);
    beats_planned++;
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, wdat);
    write_reg(CFG_IMAGE_HEIGHT, hdat);
    queue_pixels(px, 1);
    asked = $urandom_range(1, 6);
    ask_points(asked);
    aborted = 1'b0;
    wait_drained();
    // Keep asking in bursts while the walk goes on; the sender waits for every
    // point between bursts. Once in a while the walk is cut short by a reload.
    while (tphase == PH_TRACE && asked < 4 * total + 4) begin
      if (!aborted && $urandom_range(0, 5) == 0) begin
        aborted = 1'b1;
        paint_image(w, h, art, px);
        queue_pixels(px, 0);
      end
      chunk = $urandom_range(4, 16);
      ask_points(chunk);
      asked += chunk;
      wait_drained();
    end
    // Requests after the end of the walk just report that it is over.
    ask_points($urandom_range(0, 3));
  endtask

  task automatic play_random_image();
    logic [ALPHA_W-1:0] thr;
    logic [SIZE_W-1:0]  w7;
    logic [SIZE_W-1:0]  h7;
    logic [SIZE_W-1:0]  big;
    int                 pick;
    artwork_t           art;
    case ($urandom_range(0, 7))
      0:       thr = '0;
      1:       thr = 8'hFF;
      default: thr = ALPHA_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 2))
      0:       big = 7'd64;
      1:       big = 7'd127;
      default: big = SIZE_W'($urandom_range(13, 126));
    endcase
    // Mostly small pictures; a long strip now and then reaches the far columns or rows.
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      w7 = big;
      h7 = SIZE_W'($urandom_range(1, 3));
    end else if (pick == 1) begin
      w7 = SIZE_W'($urandom_range(1, 3));
      h7 = big;
    end else begin
      w7 = SIZE_W'($urandom_range(0, 12));
      h7 = SIZE_W'($urandom_range(0, 12));
    end
    case ($urandom_range(0, 9))
      0:          art = ART_EMPTY;
      1:          art = ART_SOLID;
      2:          art = ART_RAW;
      3, 4, 5, 6: art = ART_NOISE;
      default:    art = ART_BLOBS;
    endcase
    play_image(thr, {1'($urandom_range(0, 1)), w7}, {1'($urandom_range(0, 1)), h7}, art);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing loaded yet, so this request must vanish.
    queue_beat(KIND_REQUEST, 8'hA5);
    wait_idle();

    // Small 3 by 2 picture with alphas at and just above the threshold:
    //   row 0: 255 49 48   -> opaque, opaque, clear
    //   row 1:   0 255 200 -> clear, opaque, opaque
    write_reg(CFG_ALPHA_THRESHOLD, 8'd48);
    write_reg(CFG_IMAGE_WIDTH, 8'd3);
    write_reg(CFG_IMAGE_HEIGHT, 8'd2);
    queue_beat(KIND_LOAD, 8'd255);
    queue_beat(KIND_LOAD, 8'd49);
    queue_beat(KIND_LOAD, 8'd48);
    queue_beat(KIND_REQUEST, 8'h5A);
    queue_beat(KIND_LOAD, 8'd0);
    queue_beat(KIND_LOAD, 8'd255);
    queue_beat(KIND_LOAD, 8'd200);
    beats_planned += 6;
    ask_points(6);

    // Loading into the full image restarts it; an all clear picture reports empty.
    repeat (6) queue_beat(KIND_LOAD, 8'd0);
    beats_planned += 6;
    ask_points(2);

    // Register extremes: clamped widths and heights, zero sizes, both threshold ends.
    play_image(8'd0, 8'd127, 8'd1, ART_NOISE);
    play_image(8'hFF, 8'd0, 8'd0, ART_SOLID);
    play_image(8'd48, 8'd1, 8'd64, ART_NOISE);
    play_image(8'd100, 8'd2, 8'd1, ART_SOLID);
    play_image(ALPHA_W'($urandom_range(0, 254)), 8'd64, 8'd3, ART_BLOBS);
    play_image(ALPHA_W'($urandom_range(0, 254)), 8'd3, 8'hFF, ART_BLOBS);
    play_image(8'd0, 8'd1, 8'd1, ART_SOLID);
    play_image(ALPHA_W'($urandom_range(0, 255)), 8'd5, 8'd4, ART_RAW);

    while (beats_planned < TARGET_BEATS) play_random_image();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && contour_expect_q.size() == 0) begin
      $display("silhouette_contour_tracer_tb passed");
    end else begin
      $display("silhouette_contour_tracer_tb failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("silhouette_contour_tracer_tb failed");
    $finish;
  end

endmodule
